### rtl/core/assert_macros.svh
// shared assertion helpers for the peak finder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside of reset
`define WPPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define WPPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/wppf_pkg.sv
package wppf_pkg;

  localparam int ADC_W  = 12;
  localparam int PED_W  = 16;
  localparam int THR_W  = 24;
  localparam int TICK_W = 12;
  localparam int REP_W  = 13;
  localparam int VAL_W  = 30;
  localparam int RAW_W  = 18;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_IND = 1'b0,
    REG_THR_COL = 1'b1
  } cfg_reg_t;

  localparam logic REC_PEAK = 1'b0;
  localparam logic REC_END  = 1'b1;

  localparam logic signed [VAL_W-1:0] SAT_HI = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] SAT_LO = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [REP_W-1:0]        REP_MAX = {REP_W{1'b1}};

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic              kind;
    logic [TICK_W-1:0] rise_tick;
    logic [TICK_W-1:0] peak_tick;
    logic [TICK_W-1:0] close_tick;
    logic [REP_W-1:0]  rep_cnt;
    logic              last;
  } wppf_rec_t;

endpackage

### rtl/core/wppf_detect.sv
`include "assert_macros.svh"

module wppf_detect import wppf_pkg::*; #(
  parameter int MAX_BLOCK_LEN = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  cfg_reg_t          cfg_idx,
  input  logic [THR_W-1:0]  cfg_wdata,
  input  logic              fire,
  input  logic [ADC_W-1:0]  s_adc,
  input  logic [PED_W-1:0]  s_ped,
  input  logic              s_ind,
  input  logic              s_first,
  input  logic              s_last,
  output logic              push_a,
  output wppf_rec_t         rec_a,
  output logic              push_b,
  output wppf_rec_t         rec_b
);

  localparam int IDX_W = $clog2(MAX_BLOCK_LEN + 1);
  localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_BLOCK_LEN);

  logic [THR_W-1:0]        thr_ind;
  logic [THR_W-1:0]        thr_col;
  logic signed [VAL_W-1:0] window_older;
  logic signed [VAL_W-1:0] window_newer;
  logic signed [VAL_W-1:0] running_integral;
  logic [IDX_W-1:0]        sample_index;
  logic                    peak_pending;
  logic [TICK_W-1:0]       start_holder;
  logic [REP_W-1:0]        unmatched_peaks;

  logic signed [VAL_W-1:0] window_older_next;
  logic signed [VAL_W-1:0] window_newer_next;
  logic signed [VAL_W-1:0] running_integral_next;
  logic [IDX_W-1:0]        sample_index_next;
  logic                    peak_pending_next;
  logic [TICK_W-1:0]       start_holder_next;
  logic [REP_W-1:0]        unmatched_peaks_next;

  logic signed [VAL_W-1:0] eff_older;
  logic signed [VAL_W-1:0] eff_newer;
  logic signed [VAL_W-1:0] eff_int;
  logic [IDX_W-1:0]        eff_index;
  logic                    eff_pending;
  logic [TICK_W-1:0]       eff_start;
  logic [REP_W-1:0]        eff_unmatched;

  logic                    in_range;
  logic                    tick_ge2;
  logic [IDX_W-1:0]        tick_m1;
  logic [IDX_W-1:0]        last_tick;
  logic signed [RAW_W-1:0] value;
  logic [VAL_W:0]          sum_wide;
  logic signed [VAL_W-1:0] sum_sat;
  logic signed [VAL_W-1:0] cur;
  logic signed [VAL_W-1:0] thr_s;
  logic                    is_min;
  logic                    is_max;
  logic                    a_valid;
  logic                    pend_mid;
  logic [TICK_W-1:0]       start_mid;
  logic [REP_W-1:0]        unm_mid;

  // a block start drops the stored block state before this sample
  always_comb begin
    eff_older     = s_first ? '0 : window_older;
    eff_newer     = s_first ? '0 : window_newer;
    eff_int       = s_first ? '0 : running_integral;
    eff_index     = s_first ? '0 : sample_index;
    eff_pending   = s_first ? 1'b0 : peak_pending;
    eff_start     = s_first ? '0 : start_holder;
    eff_unmatched = s_first ? '0 : unmatched_peaks;
  end

  assign in_range  = eff_index < IDX_LIMIT;
  assign tick_ge2  = eff_index >= IDX_W'(2);
  assign tick_m1   = eff_index - IDX_W'(1);
  assign last_tick = in_range ? eff_index : tick_m1;

  // pedestal removal, result in signed 14.4
  assign value = $signed({2'b00, s_adc, 4'b0000}) - $signed({2'b00, s_ped});

  assign sum_wide = {eff_int[VAL_W-1], eff_int}
                  + {{(VAL_W+1-RAW_W){value[RAW_W-1]}}, value};

  always_comb begin
    if (sum_wide[VAL_W] != sum_wide[VAL_W-1]) begin
      sum_sat = sum_wide[VAL_W] ? SAT_LO : SAT_HI;
    end else begin
      sum_sat = $signed(sum_wide[VAL_W-1:0]);
    end
  end

  assign cur   = s_ind ? sum_sat : VAL_W'(value);
  assign thr_s = $signed({{(VAL_W-THR_W){1'b0}}, (s_ind ? thr_ind : thr_col)});

  assign is_min = (eff_older > eff_newer) && (eff_newer < cur);
  assign is_max = (eff_older < eff_newer) && (eff_newer > cur) && (eff_newer > thr_s);

  always_comb begin
    a_valid   = 1'b0;
    rec_a     = '0;
    pend_mid  = eff_pending;
    start_mid = eff_start;
    unm_mid   = eff_unmatched;
    if (in_range && tick_ge2) begin
      if (is_min) begin
        if (eff_pending) begin
          a_valid          = 1'b1;
          rec_a.kind       = REC_END;
          rec_a.close_tick = TICK_W'(tick_m1);
          rec_a.rep_cnt    = REP_W'(1);
          if (eff_unmatched != '0) begin
            unm_mid = eff_unmatched - REP_W'(1);
          end
          pend_mid  = 1'b0;
          start_mid = TICK_W'(eff_index);
        end else begin
          start_mid = TICK_W'(tick_m1);
        end
      end else if (is_max) begin
        a_valid         = 1'b1;
        pend_mid        = 1'b1;
        rec_a.kind      = REC_PEAK;
        rec_a.rise_tick = eff_start;
        rec_a.peak_tick = TICK_W'(tick_m1);
        if (eff_unmatched != REP_MAX) begin
          unm_mid = eff_unmatched + REP_W'(1);
        end
      end
    end
    // block flush closes every peak still open
    rec_b            = '0;
    rec_b.kind       = REC_END;
    rec_b.close_tick = TICK_W'(last_tick);
    rec_b.rep_cnt    = unm_mid;
    rec_b.last       = 1'b1;
    rec_a.last       = !(s_last && (unm_mid != '0));
  end

  assign push_a = fire && a_valid;
  assign push_b = fire && s_last && (unm_mid != '0);

  always_comb begin
    window_older_next     = eff_older;
    window_newer_next     = eff_newer;
    running_integral_next = eff_int;
    sample_index_next     = eff_index;
    peak_pending_next     = pend_mid;
    start_holder_next     = start_mid;
    unmatched_peaks_next  = unm_mid;
    if (s_last) begin
      window_older_next     = '0;
      window_newer_next     = '0;
      running_integral_next = '0;
      sample_index_next     = '0;
      peak_pending_next     = 1'b0;
      start_holder_next     = '0;
      unmatched_peaks_next  = '0;
    end else if (in_range) begin
      window_older_next     = eff_newer;
      window_newer_next     = cur;
      running_integral_next = sum_sat;
      sample_index_next     = eff_index + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_ind          <= '0;
      thr_col          <= '0;
      window_older     <= '0;
      window_newer     <= '0;
      running_integral <= '0;
      sample_index     <= '0;
      peak_pending     <= 1'b0;
      start_holder     <= '0;
      unmatched_peaks  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_THR_IND: thr_ind <= cfg_wdata;
          REG_THR_COL: thr_col <= cfg_wdata;
          default:     thr_ind <= thr_ind;
        endcase
      end
      if (fire) begin
        window_older     <= window_older_next;
        window_newer     <= window_newer_next;
        running_integral <= running_integral_next;
        sample_index     <= sample_index_next;
        peak_pending     <= peak_pending_next;
        start_holder     <= start_holder_next;
        unmatched_peaks  <= unmatched_peaks_next;
      end
    end
  end

  `WPPF_ASSERT(a_pending_has_count, peak_pending |-> (unmatched_peaks != '0),
               "pending peak with zero unmatched count")
  `WPPF_ASSERT(a_index_bound, sample_index <= IDX_LIMIT,
               "sample index beyond block limit")
  `WPPF_ASSERT(a_end_closes_one,
               (push_a && rec_a.kind == REC_END) |-> (rec_a.rep_cnt == REP_W'(1)),
               "window end record must close exactly one peak")

endmodule

### rtl/core/wppf_result_fifo.sv
`include "assert_macros.svh"

module wppf_result_fifo import wppf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_a,
  input  wppf_rec_t rec_a,
  input  logic      push_b,
  input  wppf_rec_t rec_b,
  input  logic      pop,
  output logic      room,
  output logic      not_empty,
  output wppf_rec_t head
);

  wppf_rec_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_b;
  logic [CNT_W-1:0] count_next;

  // room for a full pair of words from one sample
  assign room      = count <= CNT_W'(FIFO_DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  assign wr_ptr_b   = wr_ptr + PTR_W'(push_a);
  assign count_next = count + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= rec_a;
    end
    if (push_b) begin
      mem[wr_ptr_b] <= rec_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_a) + PTR_W'(push_b);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  `WPPF_ASSERT(a_count_bound, count <= CNT_W'(FIFO_DEPTH),
               "result queue count beyond depth")
  `WPPF_ASSERT(a_no_overflow, (push_a || push_b) |-> room,
               "result pushed without room for a pair")
  `WPPF_ASSERT(a_no_underflow, pop |-> not_empty,
               "result popped from empty queue")

endmodule

### rtl/core/wire_pulse_peak_finder.sv
// wire pulse peak finder
// one converter word per in_valid/in_ready handshake: adc_sample, pedestal_level,
// is_induction, first_of_block, last_of_block. each word yields zero, one or two
// result words on out_valid/out_ready: a peak record (record_kind 0, rise_tick,
// peak_tick) or an end record (record_kind 1, close_tick, end_repeat); last_result
// marks the final word caused by a given input word.
// thresholds are written on the cfg channel (index 0 induction, 1 collection);
// the user must write them only while the block is idle, the block does not
// enforce this; cfg_ready is always high. an accepted word waits in the input
// register until the queue has room, then is processed into the result queue.
// throughput: one input word per cycle while each word yields at most one result;
// the input stage advances only when the 4-entry result queue has room for two
// words, so a two-result word or a stalled receiver slows intake to the rate at
// which results are taken. stalls hold results in the queue, nothing is dropped.
// reset (synchronous, active high) clears thresholds, block state and the queue.
module wire_pulse_peak_finder import wppf_pkg::*; #(
  parameter int MAX_BLOCK_LEN = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADC_W-1:0]     adc_sample,
  input  logic [PED_W-1:0]     pedestal_level,
  input  logic                 is_induction,
  input  logic                 first_of_block,
  input  logic                 last_of_block,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 record_kind,
  output logic [TICK_W-1:0]    rise_tick,
  output logic [TICK_W-1:0]    peak_tick,
  output logic [TICK_W-1:0]    close_tick,
  output logic [REP_W-1:0]     end_repeat,
  output logic                 last_result,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  // input register stage
  logic              s_valid;
  logic [ADC_W-1:0]  s_adc;
  logic [PED_W-1:0]  s_ped;
  logic              s_ind;
  logic              s_first;
  logic              s_last;

  logic              fire;
  logic              room;
  logic              push_a;
  logic              push_b;
  wppf_rec_t         rec_a;
  wppf_rec_t         rec_b;
  wppf_rec_t         head;
  logic              pop;

  // the staged word moves on when the queue can take both possible results
  assign fire     = s_valid && room;
  assign in_ready = !s_valid || fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_adc   <= adc_sample;
      s_ped   <= pedestal_level;
      s_ind   <= is_induction;
      s_first <= first_of_block;
      s_last  <= last_of_block;
    end
  end

  wppf_detect #(
    .MAX_BLOCK_LEN(MAX_BLOCK_LEN)
  ) u_detect (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_reg_t'(cfg_index)),
    .cfg_wdata(cfg_data),
    .fire     (fire),
    .s_adc    (s_adc),
    .s_ped    (s_ped),
    .s_ind    (s_ind),
    .s_first  (s_first),
    .s_last   (s_last),
    .push_a   (push_a),
    .rec_a    (rec_a),
    .push_b   (push_b),
    .rec_b    (rec_b)
  );

  wppf_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_a   (push_a),
    .rec_a    (rec_a),
    .push_b   (push_b),
    .rec_b    (rec_b),
    .pop      (pop),
    .room     (room),
    .not_empty(out_valid),
    .head     (head)
  );

  assign pop = out_valid && out_ready;

  // result fields straight from the queue head
  assign record_kind = head.kind;
  assign rise_tick   = head.rise_tick;
  assign peak_tick   = head.peak_tick;
  assign close_tick  = head.close_tick;
  assign end_repeat  = head.rep_cnt;
  assign last_result = head.last;

endmodule
